### rtl/core/indexed_list_engine_macros.svh
// Assertion macros used by the top level of the list engine.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Check that a condition implies a property in the same cycle.
`define ILE_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("list engine check failed");

// Check that a condition implies a property in the next cycle.
`define ILE_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("list engine check failed");

`endif

### rtl/core/ile_pkg.sv
// Types, codes and sizing constants of the indexed list engine.
package ile_pkg;

    localparam int CAPACITY      = 64;
    localparam int ELEMENT_WIDTH = 32;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed field widths of the transactions
    localparam int MODE_W   = 4;
    localparam int POS_W    = 7;
    localparam int ELEM_F_W = 32;
    localparam int STATUS_W = 3;
    localparam int VAL_W    = 32;
    localparam int FIDX_W   = 6;
    localparam int LEN_W    = 7;

    localparam logic [MODE_W-1:0] MODE_APPEND   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SET      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_GET      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_POP      = 4'd5;
    localparam logic [MODE_W-1:0] MODE_INDEX_OF = 4'd6;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [POS_W-1:0]    position;
        logic [ELEM_F_W-1:0] element;
    } ile_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value;
        logic [FIDX_W-1:0]   found_index;
        logic                found;
        logic [LEN_W-1:0]    length;
        logic                empty_res;
    } ile_res_t;

    // Access request from the sequencer to the entry memory
    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic [ELEMENT_WIDTH-1:0] wdata;
        logic                     re;
        logic [IDX_W-1:0]         raddr;
    } ile_ram_req_t;

endpackage

### rtl/core/indexed_list_engine.sv
// Top level of the indexed list engine: sequencer plus entry memory.
//
// Usage: drive a command transaction on cmd and raise start; it is taken at
// the rising edge where start is high and busy is low. Each command yields
// exactly one result transaction on result, marked by a one-cycle done
// strobe; the receiver cannot stall, so sample result whenever done is high.
// Append, set, clear, rejected or unknown commands, insert at the tail and
// searches of an empty list finish without a walk. Get reads its entry; remove
// and pop at position p shift the entries above p down; insert at position p
// shifts the entries from p up, then writes the new element; index_of and
// contains scan from the head and stop at the first match. A shift walks the
// entry memory with one read and one write per cycle on its two ports.
// A new command may be accepted in the same cycle as the done strobe.
// Reset empties the list at once: the count goes to zero and the memory
// contents are left as they are, since only entries below the count are read.
module indexed_list_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ile_pkg::ile_cmd_t cmd,
    output logic              busy,
    output logic              done,
    output ile_pkg::ile_res_t result
);
    import ile_pkg::*;

    ile_ram_req_t             req;
    logic [ELEMENT_WIDTH-1:0] rdata;

    // Decode commands and sequence shifts and searches
    ile_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result),
        .req    (req),
        .rdata  (rdata)
    );

    // Hold the entries; a shift reads one entry while it writes an earlier read
    // entry to its neighbor, and the walk never reads back an entry it already moved.
    ile_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (rdata)
    );

`include "indexed_list_engine_macros.svh"

    // Length stays within capacity
    `ILE_ASSERT_NOW(a_len_ok, done, result.length <= LEN_W'(CAPACITY))
    // The empty flag tracks the length
    `ILE_ASSERT_NOW(a_empty_ok, done, result.empty_res == (result.length == '0))
    // An accepted command either finishes next cycle or keeps the engine busy
    `ILE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
    // A shift never writes the entry it reads in the same cycle
    `ILE_ASSERT_NOW(a_no_overlap, req.we && req.re, req.waddr != req.raddr)
    // A found element always reports success
    `ILE_ASSERT_NOW(a_found_ok, done && result.found, result.status == ST_OK)

endmodule

### rtl/core/ile_ram.sv
// Generic simple dual-port RAM with registered read data.
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ile_ctrl.sv
// Sequencer of the list engine: decodes commands and walks the entry memory.
module ile_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ile_pkg::ile_cmd_t    cmd,
    output logic                 busy,
    output logic                 done,
    output ile_pkg::ile_res_t    result,
    output ile_pkg::ile_ram_req_t req,
    input  logic [ile_pkg::ELEMENT_WIDTH-1:0] rdata
);
    import ile_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FILL
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [MODE_W-1:0]        mode_reg, mode_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [ELEMENT_WIDTH-1:0] elem_reg, elem_next;
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic [IDX_W-1:0]         end_reg, end_next;
    logic                     up_reg, up_next;
    logic                     issue_reg, issue_next;
    logic                     pend_reg, pend_next;
    logic [IDX_W-1:0]         pend_addr_reg, pend_addr_next;
    logic [ELEMENT_WIDTH-1:0] value_reg, value_next;
    logic                     done_reg, done_next;
    ile_res_t                 res_reg, res_next;

    logic [ELEMENT_WIDTH-1:0] elem_in;
    logic [31:0]              pos_w;
    logic [31:0]              cnt_w;
    logic                     needs_elem;
    logic                     full;
    logic [IDX_W-1:0]         last_idx;

    logic                     fin;
    logic [STATUS_W-1:0]      fin_status;
    logic [ELEMENT_WIDTH-1:0] fin_value;
    logic [IDX_W-1:0]         fin_fidx;
    logic                     fin_found;

    assign elem_in    = cmd.element[ELEMENT_WIDTH-1:0];
    assign pos_w      = 32'(cmd.position);
    assign cnt_w      = 32'(count_reg);
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign needs_elem = (cmd.mode == MODE_APPEND) || (cmd.mode == MODE_INSERT) ||
                        (cmd.mode == MODE_SET) || (cmd.mode == MODE_INDEX_OF) ||
                        (cmd.mode == MODE_CONTAINS);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        elem_next      = elem_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        up_next        = up_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        value_next     = value_reg;
        done_next      = 1'b0;
        res_next       = res_reg;

        req.we    = 1'b0;
        req.waddr = pos_reg;
        req.wdata = rdata;
        req.re    = 1'b0;
        req.raddr = addr_reg;

        fin        = 1'b0;
        fin_status = ST_OK;
        fin_value  = '0;
        fin_fidx   = '0;
        fin_found  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = cmd.mode;
                    pos_next  = cmd.position[IDX_W-1:0];
                    elem_next = elem_in;
                    req.wdata = elem_in;
                    priority if (needs_elem && (elem_in == '0))
                    begin
                        fin        = 1'b1;
                        fin_status = ST_NULL;
                    end
                    else
                    begin
                        unique case (cmd.mode)
                            MODE_APPEND:
                            begin
                                fin = 1'b1;
                                if (full)
                                begin
                                    fin_status = ST_FULL;
                                end
                                else
                                begin
                                    req.we     = 1'b1;
                                    req.waddr  = count_reg[IDX_W-1:0];
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            MODE_INSERT:
                            begin
                                priority if (pos_w > cnt_w)
                                begin
                                    fin        = 1'b1;
                                    fin_status = ST_BAD_INDEX;
                                end
                                else if (full)
                                begin
                                    fin        = 1'b1;
                                    fin_status = ST_FULL;
                                end
                                else if (pos_w == cnt_w)
                                begin
                                    // insert at the tail is an append
                                    fin        = 1'b1;
                                    req.we     = 1'b1;
                                    req.waddr  = cmd.position[IDX_W-1:0];
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                    addr_next  = last_idx;
                                    end_next   = cmd.position[IDX_W-1:0];
                                    up_next    = 1'b0;
                                    issue_next = 1'b1;
                                end
                            end
                            MODE_SET:
                            begin
                                fin = 1'b1;
                                if (pos_w >= cnt_w)
                                begin
                                    fin_status = ST_BAD_INDEX;
                                end
                                else
                                begin
                                    req.we    = 1'b1;
                                    req.waddr = cmd.position[IDX_W-1:0];
                                end
                            end
                            MODE_REMOVE, MODE_GET, MODE_POP:
                            begin
                                if (pos_w >= cnt_w)
                                begin
                                    fin        = 1'b1;
                                    fin_status = ST_BAD_INDEX;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                    addr_next  = cmd.position[IDX_W-1:0];
                                    end_next   = (cmd.mode == MODE_GET) ?
                                                 cmd.position[IDX_W-1:0] : last_idx;
                                    up_next    = 1'b1;
                                    issue_next = 1'b1;
                                end
                            end
                            MODE_INDEX_OF, MODE_CONTAINS:
                            begin
                                if (count_reg == '0)
                                begin
                                    fin        = 1'b1;
                                    fin_status = (cmd.mode == MODE_INDEX_OF) ?
                                                 ST_NOT_FOUND : ST_OK;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                    addr_next  = '0;
                                    end_next   = last_idx;
                                    up_next    = 1'b1;
                                    issue_next = 1'b1;
                                end
                            end
                            MODE_CLEAR:
                            begin
                                fin        = 1'b1;
                                count_next = '0;
                            end
                            default:
                            begin
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end

            S_SCAN:
            begin
                // stream reads; the data of each read arrives in the next cycle
                req.re = issue_reg;
                if (issue_reg)
                begin
                    if (addr_reg == end_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = up_reg ? (addr_reg + IDX_W'(1)) : (addr_reg - IDX_W'(1));
                    end
                end
                pend_next      = issue_reg;
                pend_addr_next = addr_reg;

                if (pend_reg)
                begin
                    unique case (mode_reg)
                        MODE_INSERT:
                        begin
                            req.we    = 1'b1;
                            req.waddr = pend_addr_reg + IDX_W'(1);
                            if (!issue_reg)
                            begin
                                state_next = S_FILL;
                            end
                        end
                        MODE_REMOVE, MODE_POP:
                        begin
                            if (pend_addr_reg == pos_reg)
                            begin
                                value_next = rdata;
                            end
                            else
                            begin
                                req.we    = 1'b1;
                                req.waddr = pend_addr_reg - IDX_W'(1);
                            end
                            if (!issue_reg)
                            begin
                                fin        = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                if (mode_reg == MODE_POP)
                                begin
                                    fin_value = (pend_addr_reg == pos_reg) ? rdata : value_reg;
                                end
                            end
                        end
                        MODE_GET:
                        begin
                            fin       = 1'b1;
                            fin_value = rdata;
                        end
                        MODE_INDEX_OF, MODE_CONTAINS:
                        begin
                            if (rdata == elem_reg)
                            begin
                                fin       = 1'b1;
                                fin_found = 1'b1;
                                fin_fidx  = pend_addr_reg;
                            end
                            else if (!issue_reg)
                            begin
                                fin        = 1'b1;
                                fin_status = (mode_reg == MODE_INDEX_OF) ?
                                             ST_NOT_FOUND : ST_OK;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                req.we     = 1'b1;
                req.waddr  = pos_reg;
                req.wdata  = elem_reg;
                count_next = count_reg + CNT_W'(1);
                fin        = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next           = S_IDLE;
            issue_next           = 1'b0;
            pend_next            = 1'b0;
            done_next            = 1'b1;
            res_next.status      = fin_status;
            res_next.value       = VAL_W'(fin_value);
            res_next.found_index = FIDX_W'(fin_fidx);
            res_next.found       = fin_found;
            res_next.length      = LEN_W'(count_next);
            res_next.empty_res   = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mode_reg      <= '0;
            pos_reg       <= '0;
            elem_reg      <= '0;
            addr_reg      <= '0;
            end_reg       <= '0;
            up_reg        <= 1'b0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            value_reg     <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            elem_reg      <= elem_next;
            addr_reg      <= addr_next;
            end_reg       <= end_next;
            up_reg        <= up_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            value_reg     <= value_next;
            done_reg      <= done_next;
            res_reg       <= res_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

### test/tb.sv
// Self-checking testbench for the indexed list engine: directed table, then random commands.
`timescale 1ns / 1ps

module tb;
    import ile_pkg::*;

    // Stop the run well past the slowest legal schedule
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1100;
    // Longest walk is a full-length shift plus setup
    localparam int DRAIN_CYCLES = 80;
    localparam int POOL_SIZE    = 16;
    // Grow and shrink phases alternate every this many random commands
    localparam int PHASE_LEN    = 200;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    ile_cmd_t cmd   = '0;
    logic     busy;
    logic     done;
    ile_res_t result;

    // Hand-typed expectation travelling with the command now on the bus
    bit       row_typed = 1'b0;
    ile_res_t row_res   = '0;

    // Shadow copy of the list kept by the predictor
    logic [ELEMENT_WIDTH-1:0] shadow_mem [CAPACITY];
    int                       shadow_len = 0;

    ile_res_t expected_q [$];
    int       err_cnt = 0;
    int       cyc_cnt = 0;

    typedef struct {
        ile_cmd_t c;
        bit       typed;
        ile_res_t r;
    } stim_row_t;

    stim_row_t                directed_rows [$];
    logic [ELEM_F_W-1:0]      elem_pool [POOL_SIZE];

    indexed_list_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Apply one command to the shadow list and return the result it must produce.
    function automatic ile_res_t predict_list(input ile_cmd_t c);
        ile_res_t                 r;
        logic [ELEMENT_WIDTH-1:0] e;
        int                       p;
        int                       k;
        bit                       needs_elem;
        r = '0;
        e = ELEMENT_WIDTH'(c.element);
        p = int'(c.position);
        needs_elem = c.mode inside {MODE_APPEND, MODE_INSERT, MODE_SET,
                                    MODE_INDEX_OF, MODE_CONTAINS};
        // Null check wins over every other rejection
        if (needs_elem && e == '0)
        begin
            r.status = ST_NULL;
        end
        else
        begin
            case (c.mode)
                MODE_APPEND:
                begin
                    if (shadow_len >= CAPACITY)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        shadow_mem[shadow_len] = e;
                        shadow_len++;
                    end
                end
                MODE_INSERT:
                begin
                    // Position is checked before capacity
                    if (p > shadow_len)
                    begin
                        r.status = ST_BAD_INDEX;
                    end
                    else if (shadow_len >= CAPACITY)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        for (k = shadow_len; k > p; k--)
                        begin
                            shadow_mem[k] = shadow_mem[k-1];
                        end
                        shadow_mem[p] = e;
                        shadow_len++;
                    end
                end
                MODE_SET:
                begin
                    if (p >= shadow_len)
                    begin
                        r.status = ST_BAD_INDEX;
                    end
                    else
                    begin
                        shadow_mem[p] = e;
                    end
                end
                MODE_REMOVE, MODE_GET, MODE_POP:
                begin
                    if (p >= shadow_len)
                    begin
                        r.status = ST_BAD_INDEX;
                    end
                    else
                    begin
                        if (c.mode != MODE_REMOVE)
                        begin
                            r.value = VAL_W'(shadow_mem[p]);
                        end
                        if (c.mode != MODE_GET)
                        begin
                            for (k = p; k + 1 < shadow_len; k++)
                            begin
                                shadow_mem[k] = shadow_mem[k+1];
                            end
                            shadow_len--;
                        end
                    end
                end
                MODE_INDEX_OF, MODE_CONTAINS:
                begin
                    for (k = 0; k < shadow_len && !r.found; k++)
                    begin
                        if (shadow_mem[k] == e)
                        begin
                            r.found       = 1'b1;
                            r.found_index = FIDX_W'(k);
                        end
                    end
                    // A miss is an error only for index_of
                    if (!r.found && c.mode == MODE_INDEX_OF)
                    begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                MODE_CLEAR:
                begin
                    shadow_len = 0;
                end
                default:
                begin
                end
            endcase
        end
        r.length    = LEN_W'(shadow_len);
        r.empty_res = (shadow_len == 0);
        return r;
    endfunction

    task automatic compare_result(input ile_res_t exp_r, input ile_res_t act_r);
        if (act_r.status !== exp_r.status)
        begin
            $error("status: expected %0d, got %0d", exp_r.status, act_r.status);
            err_cnt++;
        end
        if (act_r.value !== exp_r.value)
        begin
            $error("value: expected %08h, got %08h", exp_r.value, act_r.value);
            err_cnt++;
        end
        if (act_r.found_index !== exp_r.found_index)
        begin
            $error("found_index: expected %0d, got %0d", exp_r.found_index,
                   act_r.found_index);
            err_cnt++;
        end
        if (act_r.found !== exp_r.found)
        begin
            $error("found: expected %0d, got %0d", exp_r.found, act_r.found);
            err_cnt++;
        end
        if (act_r.length !== exp_r.length)
        begin
            $error("length: expected %0d, got %0d", exp_r.length, act_r.length);
            err_cnt++;
        end
        if (act_r.empty_res !== exp_r.empty_res)
        begin
            $error("empty_res: expected %0d, got %0d", exp_r.empty_res, act_r.empty_res);
            err_cnt++;
        end
    endtask

    // Sample at the rising edge: retire a finished transaction first, then log a new one.
    // A command may be taken on the same edge that strobes the previous result.
    always @(posedge clk)
    begin : result_monitor
        ile_res_t exp_r;
        ile_res_t pred_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result strobed with no command outstanding");
                    err_cnt++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    compare_result(exp_r, result);
                end
            end
            if (start && !busy)
            begin
                // Always advance the shadow list, even when the row carries its own answer
                pred_r = predict_list(cmd);
                expected_q.push_back(row_typed ? row_res : pred_r);
            end
        end
    end

    always @(posedge clk)
    begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the command is taken.
    task automatic send_cmd(input ile_cmd_t c, input int gap, input bit typed,
                            input ile_res_t tr);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        row_typed <= typed;
        row_res   <= tr;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // Mostly short idle bursts, now and then a long one to land mid-walk.
    function automatic int idle_gap(input bit quiet);
        int g;
        g = 0;
        if (!quiet)
        begin
            while ($urandom_range(99) < 9)
            begin
                g++;
            end
            if ($urandom_range(99) < 3)
            begin
                g += $urandom_range(70, 1);
            end
        end
        return g;
    endfunction

    function automatic ile_cmd_t make_cmd(input logic [MODE_W-1:0] m, input int p,
                                          input logic [ELEM_F_W-1:0] e);
        ile_cmd_t c;
        c.mode     = m;
        c.position = POS_W'(p);
        c.element  = e;
        return c;
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] m, input int p,
                           input logic [ELEM_F_W-1:0] e);
        stim_row_t row;
        row.c     = make_cmd(m, p, e);
        row.typed = 1'b0;
        row.r     = '0;
        directed_rows.push_back(row);
    endtask

    // Row whose answer is typed in; searches never hit here, so found stays clear.
    task automatic add_checked_row(input logic [MODE_W-1:0] m, input int p,
                                   input logic [ELEM_F_W-1:0] e,
                                   input logic [STATUS_W-1:0] st,
                                   input logic [VAL_W-1:0] v, input int len);
        stim_row_t row;
        row.c             = make_cmd(m, p, e);
        row.typed         = 1'b1;
        row.r             = '0;
        row.r.status      = st;
        row.r.value       = v;
        row.r.length      = LEN_W'(len);
        row.r.empty_res   = (len == 0);
        directed_rows.push_back(row);
    endtask

    // Random command shaped by the current fill level: grow phases push the list
    // to capacity, shrink phases drain it, with bad indexes and noise mixed in.
    function automatic ile_cmd_t rand_cmd(input bit grow);
        ile_cmd_t c;
        int       w;
        int       hi;
        w = $urandom_range(99);
        if (grow)
        begin
            c.mode = (w < 35) ? MODE_APPEND   : (w < 60) ? MODE_INSERT :
                     (w < 68) ? MODE_SET      : (w < 74) ? MODE_GET    :
                     (w < 81) ? MODE_INDEX_OF : (w < 88) ? MODE_CONTAINS :
                     (w < 92) ? MODE_REMOVE   : (w < 96) ? MODE_POP    :
                     (w < 97) ? MODE_CLEAR    : MODE_W'($urandom_range(15, 9));
        end
        else
        begin
            c.mode = (w < 25) ? MODE_REMOVE   : (w < 50) ? MODE_POP    :
                     (w < 58) ? MODE_GET      : (w < 64) ? MODE_SET    :
                     (w < 72) ? MODE_INDEX_OF : (w < 80) ? MODE_CONTAINS :
                     (w < 88) ? MODE_APPEND   : (w < 94) ? MODE_INSERT :
                     (w < 96) ? MODE_CLEAR    : MODE_W'($urandom_range(15, 9));
        end
        // Pure noise: any mode code, with position and element drawn as usual
        if (w == 99)
        begin
            c.mode = MODE_W'($urandom_range(15));
        end

        hi = (c.mode == MODE_INSERT) ? shadow_len : shadow_len - 1;
        if (hi < 0 || $urandom_range(99) < 8)
        begin
            c.position = POS_W'($urandom_range(127));
        end
        else
        begin
            c.position = POS_W'($urandom_range(hi));
        end

        w = $urandom_range(99);
        if (w < 4)
        begin
            c.element = '0;
        end
        else if (w < 14)
        begin
            c.element = $urandom;
        end
        else
        begin
            // Reuse a small pool so that searches and duplicates hit often
            c.element = elem_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return c;
    endfunction

    initial
    begin : stimulus
        int i;
        bit grow;
        bit quiet;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            elem_pool[i] = $urandom | 32'h1;
        end

        // Empty list: every indexed access is out of range
        add_checked_row(MODE_GET,      0,   32'h0000_0001, ST_BAD_INDEX, '0, 0);
        add_checked_row(MODE_POP,      0,   32'h0000_0001, ST_BAD_INDEX, '0, 0);
        add_checked_row(MODE_REMOVE,   0,   32'h0000_0001, ST_BAD_INDEX, '0, 0);
        add_checked_row(MODE_SET,      0,   32'h0000_0005, ST_BAD_INDEX, '0, 0);
        add_checked_row(MODE_APPEND,   0,   32'h0000_0000, ST_NULL,      '0, 0);
        add_checked_row(MODE_INDEX_OF, 0,   32'h0000_0007, ST_NOT_FOUND, '0, 0);
        add_checked_row(MODE_CONTAINS, 0,   32'h0000_0007, ST_OK,        '0, 0);
        add_checked_row(MODE_INSERT,   1,   32'h0000_0003, ST_BAD_INDEX, '0, 0);
        // Build up from the extremes of the element word
        add_checked_row(MODE_INSERT,   0,   32'hFFFF_FFFF, ST_OK,        '0, 1);
        add_checked_row(MODE_GET,      0,   32'h0000_0000, ST_OK, 32'hFFFF_FFFF, 1);
        add_checked_row(MODE_APPEND,   0,   32'h0000_0001, ST_OK,        '0, 2);
        add_checked_row(MODE_APPEND,   127, 32'h8000_0000, ST_OK,        '0, 3);
        add_checked_row(MODE_INSERT,   3,   32'h1234_5678, ST_OK,        '0, 4);
        add_row(MODE_INSERT,   1,   32'hAAAA_AAAA);
        add_row(MODE_GET,      1,   32'h0000_0000);
        add_row(MODE_INDEX_OF, 0,   32'h0000_0001);
        add_row(MODE_CONTAINS, 0,   32'h1234_5678);
        add_checked_row(MODE_CONTAINS, 0,   32'h0000_0000, ST_NULL,      '0, 5);
        add_row(MODE_SET,      4,   32'h5555_5555);
        add_row(MODE_POP,      0,   32'h0000_0000);
        add_row(MODE_REMOVE,   3,   32'h0000_0000);
        add_checked_row(MODE_GET,      127, 32'h0000_0000, ST_BAD_INDEX, '0, 3);
        // Unused mode codes do nothing, not even the null check
        add_checked_row(MODE_W'(15),   0,   32'hFFFF_FFFF, ST_OK,        '0, 3);
        add_checked_row(MODE_W'(9),    64,  32'h0000_0000, ST_OK,        '0, 3);
        add_checked_row(MODE_CLEAR,    0,   32'h0000_0000, ST_OK,        '0, 0);
        add_checked_row(MODE_POP,      0,   32'h0000_0000, ST_BAD_INDEX, '0, 0);

        // Hold reset, then release it on a falling edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_cmd(directed_rows[i].c, idle_gap(1'b0), directed_rows[i].typed,
                     directed_rows[i].r);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            grow  = ((i / PHASE_LEN) % 2) == 0;
            // Keep one stretch fully back-to-back
            quiet = (i >= 400 && i < 600);
            send_cmd(rand_cmd(grow), idle_gap(quiet), 1'b0, '0);
        end
        start <= 1'b0;

        // Drain outstanding transactions, then watch for stray strobes
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ile_pkg.sv
rtl/core/ile_ram.sv
rtl/core/ile_ctrl.sv
rtl/core/indexed_list_engine.sv
test/tb.sv
